[src/asfd_pkg.sv]
`timescale 1ns / 1ps

package asfd_pkg;

  // Marker register file
  localparam int unsigned NumMarkers    = 6;
  localparam int unsigned MarkerWidth   = 8;
  localparam int unsigned CfgIndexWidth = 3;

  // Register indexes, which are also the match priority order
  localparam logic [CfgIndexWidth-1:0] REG_MARKER_WIDE_ADC   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MARKER_TEMP_ONE   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MARKER_TEMP_FOUR  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_MARKER_NARROW_ADC = 3'd5;

  // Payload lengths in bytes
  localparam logic [2:0] WIDE_PAYLOAD_BYTES   = 3'd4;
  localparam logic [2:0] NARROW_PAYLOAD_BYTES = 3'd3;

  typedef logic [NumMarkers-1:0][MarkerWidth-1:0] marker_array_t;

  typedef enum logic [1:0] {
    KIND_WIDE   = 2'd0,
    KIND_NARROW = 2'd1,
    KIND_TEMP   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              frame_kind;
    logic [2:0]         sensor_number;
    logic signed [31:0] sample_value;
    logic               redundancy_error;
  } frame_t;

endpackage

[src/asfd_stream_if.sv]
`timescale 1ns / 1ps

// Byte channel from the serial link
interface asfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] serial_byte;

  modport source (output valid, output serial_byte, input ready);
  modport sink (input valid, input serial_byte, output ready);
endinterface

// Decoded frame channel
interface asfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic [2:0]         sensor_number;
  logic signed [31:0] sample_value;
  logic               redundancy_error;

  modport source (output valid, output frame_kind, output sensor_number,
                  output sample_value, output redundancy_error, input ready);
  modport sink (input valid, input frame_kind, input sensor_number,
                input sample_value, input redundancy_error, output ready);
endinterface

[src/asfd_core.sv]
`timescale 1ns / 1ps

module asfd_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  asfd_pkg::marker_array_t markers_i,
  output logic                   res_valid_o,
  output asfd_pkg::frame_t       res_o
);

  logic                   collecting_q, collecting_d;
  asfd_pkg::kind_e        kind_q, kind_d;
  logic [2:0]             sensor_q, sensor_d;
  logic [2:0]             remaining_q, remaining_d;
  logic [31:0]            acc_q, acc_d;
  logic [31:0]            word;
  logic [asfd_pkg::NumMarkers-1:0] hit;
  logic                   temp_found;
  logic [2:0]             temp_sensor;

  // Compare the byte against every marker
  always_comb begin
    for (int i = 0; i < asfd_pkg::NumMarkers; i++) begin
      hit[i] = (markers_i[i] == byte_i);
    end
  end

  // Lowest-numbered temperature marker wins
  always_comb begin
    temp_found  = 1'b0;
    temp_sensor = '0;
    for (int i = int'(asfd_pkg::REG_MARKER_TEMP_ONE);
         i <= int'(asfd_pkg::REG_MARKER_TEMP_FOUR); i++) begin
      if (!temp_found && hit[i]) begin
        temp_found  = 1'b1;
        temp_sensor = 3'(i);
      end
    end
  end

  assign word = {acc_q[23:0], byte_i};

  // Hunt / collect step and frame formatting
  always_comb begin
    collecting_d = collecting_q;
    kind_d       = kind_q;
    sensor_d     = sensor_q;
    remaining_d  = remaining_q;
    acc_d        = acc_q;
    res_valid_o  = 1'b0;

    if (step_i) begin
      if (!collecting_q) begin
        if (hit[asfd_pkg::REG_MARKER_WIDE_ADC]) begin
          kind_d       = asfd_pkg::KIND_WIDE;
          sensor_d     = '0;
          remaining_d  = asfd_pkg::WIDE_PAYLOAD_BYTES;
          collecting_d = 1'b1;
        end else if (temp_found) begin
          kind_d       = asfd_pkg::KIND_TEMP;
          sensor_d     = temp_sensor;
          remaining_d  = asfd_pkg::NARROW_PAYLOAD_BYTES;
          collecting_d = 1'b1;
        end else if (hit[asfd_pkg::REG_MARKER_NARROW_ADC]) begin
          kind_d       = asfd_pkg::KIND_NARROW;
          sensor_d     = '0;
          remaining_d  = asfd_pkg::NARROW_PAYLOAD_BYTES;
          collecting_d = 1'b1;
        end
      end else begin
        acc_d       = word;
        remaining_d = remaining_q - 3'd1;
        if (remaining_q == 3'd1) begin
          collecting_d = 1'b0;
          res_valid_o  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.frame_kind       = kind_q;
    res_o.sensor_number    = sensor_q;
    res_o.redundancy_error = 1'b0;
    case (kind_q)
      asfd_pkg::KIND_WIDE: begin
        res_o.sample_value     = word;
        res_o.redundancy_error = word[31] ^ word[0];
      end
      asfd_pkg::KIND_NARROW: res_o.sample_value = {8'h00, word[23:0]};
      default:               res_o.sample_value = {word[23:0], 8'h00};
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      kind_q       <= asfd_pkg::KIND_WIDE;
      sensor_q     <= '0;
      remaining_q  <= '0;
    end else begin
      collecting_q <= collecting_d;
      kind_q       <= kind_d;
      sensor_q     <= sensor_d;
      remaining_q  <= remaining_d;
    end
  end

  // Payload shift register
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  a_last_byte_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && collecting_q && remaining_q == 3'd1 |=> !collecting_q)
    else $error("frame did not close on its last payload byte");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q |-> remaining_q != 3'd0 && remaining_q <= asfd_pkg::WIDE_PAYLOAD_BYTES)
    else $error("payload byte count out of range while collecting");

  a_adc_sensor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_kind != asfd_pkg::KIND_TEMP |-> res_o.sensor_number == 3'd0)
    else $error("ADC frame carries a sensor number");

  a_narrow_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_kind == asfd_pkg::KIND_NARROW
      |-> res_o.sample_value[31:24] == 8'h00 && !res_o.redundancy_error)
    else $error("narrow ADC sample not zero-extended");

endmodule

[src/adc_serial_frame_deframer.sv]
`timescale 1ns / 1ps

// Pipeline: an accepted byte is registered in the input stage, then decoded once the
//   output register can load; the frame result is registered in that register.
// Throughput: one byte per cycle while the output is not stalled by out_o.ready.
// Reset: asynchronous, active low; returns to hunting and loads markers 1 to 6.

module adc_serial_frame_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [asfd_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [asfd_pkg::MarkerWidth-1:0]    cfg_data_i,
  asfd_in_if.sink                             in_i,
  asfd_out_if.source                          out_o
);

  asfd_pkg::marker_array_t markers_q;
  logic                    s1_valid_q;
  logic [7:0]              s1_byte_q;
  logic                    out_valid_q;
  asfd_pkg::frame_t        out_q;
  logic                    out_can_load;
  logic                    step;
  logic                    in_fire;
  logic                    res_valid;
  asfd_pkg::frame_t        res;

  // Marker registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < asfd_pkg::NumMarkers; i++) begin
        markers_q[i] <= asfd_pkg::MarkerWidth'(i + 1);
      end
    end else if (cfg_we_i && cfg_index_i <= asfd_pkg::REG_MARKER_NARROW_ADC) begin
      markers_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Handshake control
  assign out_can_load = !out_valid_q || out_o.ready;
  assign step         = s1_valid_q && out_can_load;
  assign in_i.ready   = !s1_valid_q || step;
  assign in_fire      = in_i.valid && in_i.ready;

  asfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .markers_i   (markers_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.serial_byte;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.frame_kind       = out_q.frame_kind;
  assign out_o.sensor_number    = out_q.sensor_number;
  assign out_o.sample_value     = out_q.sample_value;
  assign out_o.redundancy_error = out_q.redundancy_error;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !res_valid)
    else $error("pending transaction overwritten");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_can_load && !in_fire |=> !s1_valid_q)
    else $error("input stage did not drain");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("decoded frame not registered");

endmodule
